// ===== rtl/core/smgb_pkg.sv =====
// Shared types and constants for the sprite marker glide/blink unit.
`default_nettype none

package smgb_pkg;

   localparam int unsigned CSR_ADDR_WIDTH = 5;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_START_X     = 3'd0;
   localparam logic [2:0] REG_END_X       = 3'd1;
   localparam logic [2:0] REG_START_Y     = 3'd2;
   localparam logic [2:0] REG_END_Y       = 3'd3;
   localparam logic [2:0] REG_GLIDE_TOTAL = 3'd4;
   localparam logic [2:0] REG_PRIORITY    = 3'd5;

   localparam logic [4:0]  BLINK_SHOW_MAX   = 5'd13;
   localparam logic [4:0]  BLINK_WRAP_ABOVE = 5'd19;
   localparam logic [31:0] SIZE_BITS        = 32'h4000_0000;
   localparam logic [10:0] TILE_FLAG        = 11'h400;
   localparam logic [16:0] POS_BIAS         = 17'd8;
   localparam int unsigned PRIO_SHIFT       = 28;

   // step is at most 15 bits, quotient magnitude at most 16 bits
   localparam logic [3:0] MUL_LAST = 4'd14;
   localparam logic [3:0] DIV_LAST = 4'd15;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DIV_LOAD,
      S_DIV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic mul_en;
      logic div_load;
      logic div_en;
   } lerp_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/smgb_if.sv =====
// Valid/ready channel interfaces for tick requests and sprite records.
`default_nettype none

interface smgb_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] tile_entry;

   modport source (output valid, output tile_entry, input ready);
   modport sink   (input valid, input tile_entry, output ready);
endinterface

interface smgb_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        position_word;
   logic [10:0]        tile_word;
   logic signed [15:0] marker_x;
   logic signed [15:0] marker_y;

   modport source (output valid, output position_word, output tile_word,
                   output marker_x, output marker_y, input ready);
   modport sink   (input valid, input position_word, input tile_word,
                   input marker_x, input marker_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/smgb_lerp.sv =====
// One interpolation axis: bit-serial multiply then restoring divide.
`default_nettype none

module smgb_lerp (
   input  wire logic                  clock,
   input  wire smgb_pkg::lerp_ctl_type ctl,
   input  wire logic [14:0]           step,
   input  wire logic [14:0]           total,
   input  wire logic signed [15:0]    start_v,
   input  wire logic signed [15:0]    end_v,
   output logic signed [15:0]         pos
);

   logic [15:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [14:0] step_sr_ff, step_sr_in;
   logic [30:0] acc_ff, acc_in;
   logic [14:0] rem_ff, rem_in;
   logic [15:0] num_ff, num_in;

   logic signed [16:0] diff;
   logic [16:0]        diff_abs;
   logic [15:0]        trial;
   logic               ge;

   always_comb begin
      diff     = $signed({end_v[15], end_v}) - $signed({start_v[15], start_v});
      diff_abs = diff[16] ? 17'(-diff) : 17'(diff);
      trial    = {rem_ff, num_ff[15]};
      ge       = trial >= {1'b0, total};

      mag_in     = mag_ff;
      neg_in     = neg_ff;
      step_sr_in = step_sr_ff;
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      num_in     = num_ff;

      if (ctl.load) begin
         mag_in     = diff_abs[15:0];
         neg_in     = diff[16];
         step_sr_in = step;
         acc_in     = '0;
      end
      // shift-add, step bits MSB first
      if (ctl.mul_en) begin
         acc_in     = {acc_ff[29:0], 1'b0} + (step_sr_ff[14] ? 31'(mag_ff) : 31'd0);
         step_sr_in = {step_sr_ff[13:0], 1'b0};
      end
      // quotient fits 16 bits, so the top 15 product bits start below the divisor
      if (ctl.div_load) begin
         rem_in = acc_ff[30:16];
         num_in = acc_ff[15:0];
      end
      if (ctl.div_en) begin
         rem_in = ge ? 15'(trial - {1'b0, total}) : trial[14:0];
         num_in = {num_ff[14:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      step_sr_ff <= step_sr_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      num_ff     <= num_in;
   end

   assign pos = start_v + (neg_ff ? $signed(-num_ff) : $signed(num_ff));

endmodule

`default_nettype wire

// ===== rtl/core/sprite_marker_glide_blink_unit.sv =====
// Top level: frame-tick sprite marker with linear glide and blink record output.
// Glide tick: after accept the bit-serial axis units multiply, load the divider and
// divide; the done state then registers the record and takes the sequencer back to idle.
// Other ticks: accept goes straight to the done state. Done waits while an earlier record is untaken.
// One tick in flight; the next is taken while a record waits.
// Reset (synchronous, active high) clears registers, glide, step, position, blink.
`default_nettype none

module sprite_marker_glide_blink_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   smgb_req_if.sink         req_if,
   smgb_rsp_if.source       rsp_if,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [smgb_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [smgb_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [smgb_pkg::CSR_DATA_WIDTH-1:0]      csr_prdata,
   output logic             csr_pready
);

   smgb_pkg::state_type state_ff, state_in;
   smgb_pkg::lerp_ctl_type ctl;

   logic signed [15:0] start_x_ff, end_x_ff, start_y_ff, end_y_ff;
   logic [14:0]        total_ff;
   logic [1:0]         prio_ff;
   logic               active_ff;
   logic [15:0]        step_ff;
   logic signed [15:0] pos_x_ff, pos_y_ff;
   logic [4:0]         blink_ff;
   logic [3:0]         cnt_ff, cnt_in;
   logic [10:0]        tile_ff;
   logic               glide_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        pword_ff;
   logic [10:0]        tword_ff;
   logic signed [15:0] mx_ff, my_ff;

   logic               wr_en;
   logic [2:0]         reg_idx;
   logic               accept, finish;
   logic [15:0]        step_next;
   logic signed [15:0] lerp_x, lerp_y, new_x, new_y;
   logic [4:0]         blink_base, blink_inc;
   logic               emit;
   logic [16:0]        xw;
   logic [15:0]        yw;
   logic [31:0]        pword;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[4:2];

   always_comb begin
      case (reg_idx)
         smgb_pkg::REG_START_X:     csr_prdata = 32'({16'h0, start_x_ff});
         smgb_pkg::REG_END_X:       csr_prdata = 32'({16'h0, end_x_ff});
         smgb_pkg::REG_START_Y:     csr_prdata = 32'({16'h0, start_y_ff});
         smgb_pkg::REG_END_Y:       csr_prdata = 32'({16'h0, end_y_ff});
         smgb_pkg::REG_GLIDE_TOTAL: csr_prdata = 32'(total_ff);
         smgb_pkg::REG_PRIORITY:    csr_prdata = 32'(prio_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   assign req_if.ready = (state_ff == smgb_pkg::S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign step_next    = step_ff + 16'd1;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ctl      = '0;
      finish   = 1'b0;
      case (state_ff)
         smgb_pkg::S_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               if (active_ff) begin
                  ctl.load = 1'b1;
                  state_in = smgb_pkg::S_MUL;
               end else begin
                  state_in = smgb_pkg::S_DONE;
               end
            end
         end
         smgb_pkg::S_MUL: begin
            ctl.mul_en = 1'b1;
            cnt_in     = cnt_ff + 4'd1;
            if (cnt_ff == smgb_pkg::MUL_LAST) begin
               state_in = smgb_pkg::S_DIV_LOAD;
            end
         end
         smgb_pkg::S_DIV_LOAD: begin
            ctl.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = smgb_pkg::S_DIV;
         end
         smgb_pkg::S_DIV: begin
            ctl.div_en = 1'b1;
            cnt_in     = cnt_ff + 4'd1;
            if (cnt_ff == smgb_pkg::DIV_LAST) begin
               state_in = smgb_pkg::S_DONE;
            end
         end
         smgb_pkg::S_DONE: begin
            // hold while the output register still has a record nobody took
            if (!rsp_valid_ff || rsp_if.ready) begin
               finish   = 1'b1;
               state_in = smgb_pkg::S_IDLE;
            end
         end
         default: state_in = smgb_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smgb_pkg::S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // the axis units load the step count after this tick's increment
   smgb_lerp u_lerp_x (
      .clock   (clock),
      .ctl     (ctl),
      .step    (step_next[14:0]),
      .total   (total_ff),
      .start_v (start_x_ff),
      .end_v   (end_x_ff),
      .pos     (lerp_x)
   );

   smgb_lerp u_lerp_y (
      .clock   (clock),
      .ctl     (ctl),
      .step    (step_next[14:0]),
      .total   (total_ff),
      .start_v (start_y_ff),
      .end_v   (end_y_ff),
      .pos     (lerp_y)
   );

   // finishing a tick: position, blink, record
   always_comb begin
      new_x      = glide_ff ? lerp_x : pos_x_ff;
      new_y      = glide_ff ? lerp_y : pos_y_ff;
      blink_base = glide_ff ? 5'd0 : blink_ff;
      blink_inc  = blink_base + 5'd1;
      emit       = blink_inc <= smgb_pkg::BLINK_SHOW_MAX;
      xw         = {new_x[15], new_x} - smgb_pkg::POS_BIAS;
      yw         = 16'(new_y) - smgb_pkg::POS_BIAS[15:0];
      // negative x-8 fills the upper half with ones
      pword      = {{15{xw[16]}}, xw} | {yw, 16'h0} | smgb_pkg::SIZE_BITS
                   | (32'(prio_ff) << smgb_pkg::PRIO_SHIFT);
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (finish && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff   <= '0;
         end_x_ff     <= '0;
         start_y_ff   <= '0;
         end_y_ff     <= '0;
         total_ff     <= '0;
         prio_ff      <= '0;
         active_ff    <= 1'b0;
         step_ff      <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         blink_ff     <= '0;
         glide_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            case (reg_idx)
               smgb_pkg::REG_START_X: start_x_ff <= csr_pwdata[15:0];
               smgb_pkg::REG_END_X:   end_x_ff   <= csr_pwdata[15:0];
               smgb_pkg::REG_START_Y: start_y_ff <= csr_pwdata[15:0];
               smgb_pkg::REG_END_Y:   end_y_ff   <= csr_pwdata[15:0];
               smgb_pkg::REG_GLIDE_TOTAL: begin
                  total_ff  <= csr_pwdata[14:0];
                  step_ff   <= '0;
                  active_ff <= (csr_pwdata[14:0] != 15'd0);
               end
               smgb_pkg::REG_PRIORITY: prio_ff <= csr_pwdata[1:0];
               default: ;
            endcase
         end
         if (accept) begin
            glide_ff <= active_ff;
            if (active_ff) begin
               step_ff <= step_next;
            end
         end
         if (finish) begin
            pos_x_ff <= new_x;
            pos_y_ff <= new_y;
            blink_ff <= (blink_inc > smgb_pkg::BLINK_WRAP_ABOVE) ? 5'd0 : blink_inc;
            if (glide_ff && (step_ff >= {1'b0, total_ff})) begin
               active_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tile_ff <= req_if.tile_entry[15:5];
      end
      if (finish && emit) begin
         pword_ff <= pword;
         tword_ff <= tile_ff | smgb_pkg::TILE_FLAG;
         mx_ff    <= new_x;
         my_ff    <= new_y;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.position_word = pword_ff;
   assign rsp_if.tile_word     = tword_ff;
   assign rsp_if.marker_x      = mx_ff;
   assign rsp_if.marker_y      = my_ff;

endmodule

`default_nettype wire

// ===== rtl/core/smgb_checker.sv =====
// Port-level checks for the sprite marker unit, bound to the top level.
`default_nettype none

module smgb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_position_word,
   input wire logic [10:0] rsp_tile_word,
   input wire logic        csr_pready
);

   // no record survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("record valid after reset");

   // one tick at a time: the beat after an accept is never accepted
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request ready right after accept");

   // fixed size and tile flag bits in every record
   a_fixed_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_position_word[30] && rsp_tile_word[10]))
      else $error("record constant bits missing");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_position_word)))
      else $error("stalled record changed");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");

endmodule

bind sprite_marker_glide_blink_unit smgb_checker u_smgb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_position_word (rsp_if.position_word),
   .rsp_tile_word     (rsp_if.tile_word),
   .csr_pready        (csr_pready)
);

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for the sprite marker glide/blink unit: predicts every sprite record and checks it.
`timescale 1ns / 100ps

module tb;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 48;   // lets an in-flight glide tick finish
   localparam int ITEM_TARGET   = 850;
   localparam int REPORT_MAX    = 10;
   // addresses past the last register, writes must be ignored
   localparam logic [2:0] REG_UNUSED_6 = 3'd6;
   localparam logic [2:0] REG_UNUSED_7 = 3'd7;

   typedef struct {
      logic [31:0]        position_word;
      logic [10:0]        tile_word;
      logic signed [15:0] marker_x;
      logic signed [15:0] marker_y;
   } sprite_rec_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [smgb_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [smgb_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [smgb_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   smgb_req_if req_ch ();
   smgb_rsp_if rsp_ch ();

   sprite_marker_glide_blink_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // predicted marker state and register copies
   logic [15:0] start_x_r, end_x_r, start_y_r, end_y_r;
   logic [14:0] glide_total_r;
   logic [1:0]  prio_r;
   logic        glide_on;
   logic [15:0] glide_step;
   logic [15:0] marker_x_r, marker_y_r;
   logic [4:0]  blink_r;

   sprite_rec_type pending_records[$];
   int          mismatches = 0;
   int          items_sent = 0;
   int          cycle_count = 0;
   bit          burst_mode = 1'b0;
   int          hold_cycles = 0;

   function automatic logic [15:0] glide_point(input logic [15:0] from, input logic [15:0] to,
                                               input logic [15:0] step, input logic [14:0] total);
      longint base, span, quot;
      base = $signed(from);
      span = longint'($signed(to)) - base;
      quot = (longint'(step) * span) / longint'(total);   // truncates toward zero
      return 16'(base + quot);
   endfunction

   function automatic void advance_marker(input logic [15:0] tile);
      sprite_rec_type rec;
      int xi, yi;
      logic [31:0] xw, yw;
      if (glide_on) begin
         glide_step = glide_step + 16'd1;
         marker_y_r = glide_point(start_y_r, end_y_r, glide_step, glide_total_r);
         marker_x_r = glide_point(start_x_r, end_x_r, glide_step, glide_total_r);
         if (glide_step >= {1'b0, glide_total_r})
            glide_on = 1'b0;
         blink_r = '0;
      end
      blink_r = blink_r + 5'd1;
      if (blink_r <= smgb_pkg::BLINK_SHOW_MAX) begin
         xi = $signed(marker_x_r);
         yi = $signed(marker_y_r);
         xw = xi - int'(smgb_pkg::POS_BIAS);
         yw = yi - int'(smgb_pkg::POS_BIAS);
         rec.position_word = xw | (yw << 16) | smgb_pkg::SIZE_BITS
                             | ({30'd0, prio_r} << smgb_pkg::PRIO_SHIFT);
         rec.tile_word     = tile[15:5] | smgb_pkg::TILE_FLAG;
         rec.marker_x      = marker_x_r;
         rec.marker_y      = marker_y_r;
         pending_records.push_back(rec);
      end else if (blink_r > smgb_pkg::BLINK_WRAP_ABOVE) begin
         blink_r = '0;
      end
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("%0t: %s expected %h got %h", $time, what, want, got);
   endtask

   // record checker
   always @(posedge clock) begin
      sprite_rec_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_records.size() == 0) begin
            flag_mismatch("record with none pending, position_word", '0, rsp_ch.position_word);
         end else begin
            want = pending_records.pop_front();
            if (rsp_ch.position_word !== want.position_word)
               flag_mismatch("position_word", want.position_word, rsp_ch.position_word);
            if (rsp_ch.tile_word !== want.tile_word)
               flag_mismatch("tile_word", 32'(want.tile_word), 32'(rsp_ch.tile_word));
            if (rsp_ch.marker_x !== want.marker_x)
               flag_mismatch("marker_x", 32'(want.marker_x), 32'(rsp_ch.marker_x));
            if (rsp_ch.marker_y !== want.marker_y)
               flag_mismatch("marker_y", 32'(want.marker_y), 32'(rsp_ch.marker_y));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // record sink: random stalls per beat, long hold-off on request
   initial begin : record_sink
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         if (hold_cycles != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         stall = burst_mode ? 0 : $urandom_range(0, 12);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   task automatic send_tick(input logic [15:0] tile);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.tile_entry <= tile;
      do @(posedge clock); while (!req_ch.ready);
      advance_marker(tile);
      items_sent++;
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         smgb_pkg::REG_START_X: start_x_r = data[15:0];
         smgb_pkg::REG_END_X:   end_x_r   = data[15:0];
         smgb_pkg::REG_START_Y: start_y_r = data[15:0];
         smgb_pkg::REG_END_Y:   end_y_r   = data[15:0];
         smgb_pkg::REG_GLIDE_TOTAL: begin
            glide_total_r = data[14:0];
            glide_step    = '0;
            glide_on      = (data[14:0] != '0);
         end
         smgb_pkg::REG_PRIORITY: prio_r = data[1:0];
         default: ;
      endcase
   endtask

   // idle the block: no tick offered, every record back, in-flight tick finished
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] junk_above(input int width);
      logic [31:0] bits;
      bits = $urandom;
      return $urandom_range(0, 1) ? bits & ~((32'h1 << width) - 32'h1) : 32'h0;
   endfunction

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [14:0] pick_total();
      case ($urandom_range(0, 7))
         0: return 15'd0;
         1: return 15'd1;
         2: return 15'h7FFF;
         3, 4, 5: return 15'($urandom_range(1, 12));
         6: return 15'($urandom_range(13, 60));
         default: return 15'($urandom);
      endcase
   endfunction

   // no glide: walking-one tiles, blink shows 13, hides through 20, then restarts
   task automatic test_blink_cadence();
      logic [15:0] tile;
      for (int i = 0; i < 21; i++) begin
         tile = (i < 16) ? 16'(1 << i) : ((i % 2) ? 16'hFFFF : 16'h0000);
         send_tick(tile);
      end
   endtask

   task automatic test_glide_extremes();
      settle();
      csr_write(smgb_pkg::REG_START_X, 32'h0000_8000);
      csr_write(smgb_pkg::REG_END_X, 32'hFFFF_7FFF);
      csr_write(smgb_pkg::REG_START_Y, 32'h0000_7FFF);
      csr_write(smgb_pkg::REG_END_Y, 32'hABCD_8000);
      csr_write(smgb_pkg::REG_PRIORITY, 32'hFFFF_FFFF);
      csr_write(smgb_pkg::REG_GLIDE_TOTAL, 32'hFFFF_8003);   // masks down to 3
      repeat (4) send_tick(16'($urandom));
      settle();
      csr_write(smgb_pkg::REG_START_X, 32'h0000_7FFF);
      csr_write(smgb_pkg::REG_END_X, 32'h0000_8000);
      csr_write(smgb_pkg::REG_PRIORITY, 32'h0);
      csr_write(smgb_pkg::REG_GLIDE_TOTAL, 32'h1);
      send_tick(16'hFFFF);
      settle();
      // zero total keeps the marker parked
      csr_write(smgb_pkg::REG_GLIDE_TOTAL, 32'h0);
      send_tick(16'h0000);
   endtask

   task automatic test_unknown_register();
      settle();
      csr_write(REG_UNUSED_6, $urandom);
      csr_write(REG_UNUSED_7, $urandom);
      send_tick(16'($urandom));
   endtask

   // sink holds off long while ticks keep coming, so the block backs up
   task automatic test_backpressure();
      settle();
      csr_write(smgb_pkg::REG_GLIDE_TOTAL, 32'd6);
      burst_mode  = 1'b1;
      hold_cycles = 400;
      repeat (40) send_tick(16'($urandom));
      burst_mode = 1'b0;
   endtask

   task automatic test_random_phases();
      while (items_sent < ITEM_TARGET) begin
         settle();
         burst_mode = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1))
            csr_write(smgb_pkg::REG_START_X, {16'h0, pick_coord()} | junk_above(16));
         if ($urandom_range(0, 1))
            csr_write(smgb_pkg::REG_END_X, {16'h0, pick_coord()} | junk_above(16));
         if ($urandom_range(0, 1))
            csr_write(smgb_pkg::REG_START_Y, {16'h0, pick_coord()} | junk_above(16));
         if ($urandom_range(0, 1))
            csr_write(smgb_pkg::REG_END_Y, {16'h0, pick_coord()} | junk_above(16));
         if ($urandom_range(0, 1))
            csr_write(smgb_pkg::REG_PRIORITY, 32'($urandom_range(0, 3)) | junk_above(2));
         if ($urandom_range(0, 3) != 0)
            csr_write(smgb_pkg::REG_GLIDE_TOTAL, {17'h0, pick_total()} | junk_above(15));
         repeat ($urandom_range(8, 45)) send_tick(16'($urandom));
         burst_mode = 1'b0;
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.tile_entry = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      start_x_r      = '0;
      end_x_r        = '0;
      start_y_r      = '0;
      end_y_r        = '0;
      glide_total_r  = '0;
      prio_r         = '0;
      glide_on       = 1'b0;
      glide_step     = '0;
      marker_x_r     = '0;
      marker_y_r     = '0;
      blink_r        = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_blink_cadence();
      test_glide_extremes();
      test_unknown_register();
      test_backpressure();
      test_random_phases();
      settle();

      if (mismatches == 0 && pending_records.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sprite_marker_glide_blink_unit.f =====
rtl/core/smgb_pkg.sv
rtl/core/smgb_if.sv
rtl/core/smgb_lerp.sv
rtl/core/sprite_marker_glide_blink_unit.sv
rtl/core/smgb_checker.sv
verif/tb.sv
